// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL. All of them sample on the rising edge
// of clock and are disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/uida_pkg.sv
// ----------------------------------------------------------------------------
// uida_pkg
// Types, constants and helpers of the bitmap ID allocator.
// ----------------------------------------------------------------------------
package uida_pkg;

   // Number of usable slots and the word organization of the bitmap.
   localparam int SLOTS     = 1024;
   localparam int WORD_BITS = 32;
   localparam int WORD_CNT  = (SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int WADDR_W   = (WORD_CNT > 1) ? $clog2(WORD_CNT) : 1;
   localparam int BIT_W     = $clog2(WORD_BITS);

   // Field widths.
   localparam int SLOT_W   = 11;
   localparam int ID_W     = 17;
   localparam int OFFS_W   = 16;
   localparam int MODE_W   = 2;
   localparam int OP_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
   localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

   // Allocation modes; the unused code behaves as first-fit.
   localparam logic [MODE_W-1:0] MODE_NEXT_FIT  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_COUNTER   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FIRST_FIT = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ALLOC_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_SLOT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ID_OFFSET  = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [ID_W-1:0] free_id;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]   issued_id;
      logic [SLOT_W-1:0] cursor;
   } rsp_type;

   // Slot s (from 1) lives at bit (s-1) of the bitmap.
   function automatic logic [WADDR_W-1:0] slot_word(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] sm;
      sm = s - 1'b1;
      return sm[BIT_W +: WADDR_W];
   endfunction

   function automatic logic [BIT_W-1:0] slot_bit(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] sm;
      sm = s - 1'b1;
      return sm[BIT_W-1:0];
   endfunction

endpackage

// File: rtl/unique_id_bitmap_allocator_core.sv
// ----------------------------------------------------------------------------
// unique_id_bitmap_allocator_core
// Counter allocations, clears, ignored frees and no-ops answer in the cycle
// after acceptance; a free reads its word in ST_FREE_RD and writes it back in
// ST_FREE_WR; a search reads and checks one 32-bit word at a time, with a
// second pass when next-fit wraps. A new word is accepted in the result cycle.
// Reset clears the word valid bits at once, sets the cursor to 1 and loads the
// configuration defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module unique_id_bitmap_allocator_core
   import uida_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FREE_RD,
      ST_FREE_WR
   } state_type;

   localparam logic [SLOT_W-1:0] SLOT_ONE = SLOT_W'(1);
   localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(SLOTS);

   // Control state.
   state_type             state_ff, state_in;
   logic [MODE_W-1:0]     mode_ff, mode_in;
   logic [SLOT_W-1:0]     last_slot_ff, last_slot_in;
   logic [OFFS_W-1:0]     id_offset_ff, id_offset_in;
   logic [SLOT_W-1:0]     cursor_ff, cursor_in;
   logic [WORD_CNT-1:0]   word_vld_ff, word_vld_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  chk_vld_ff, chk_vld_in;
   logic                  rd_more_ff, rd_more_in;

   // Search and free context.
   rsp_type               rsp_data_ff, rsp_data_in;
   logic [SLOT_W-1:0]     lo_ff, lo_in;
   logic [SLOT_W-1:0]     hi_ff, hi_in;
   logic [WADDR_W-1:0]    w_lo_ff, w_lo_in;
   logic [WADDR_W-1:0]    w_hi_ff, w_hi_in;
   logic [WADDR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [WADDR_W-1:0]    chk_idx_ff, chk_idx_in;
   logic                  pass_b_ff, pass_b_in;
   logic                  next_fit_ff, next_fit_in;
   logic [SLOT_W-1:0]     nf_start_ff, nf_start_in;
   logic [WADDR_W-1:0]    free_word_ff, free_word_in;
   logic [BIT_W-1:0]      free_bit_ff, free_bit_in;

   // Bitmap memory.
   logic [WORD_BITS-1:0]  bitmap_ff [WORD_CNT];
   logic [WORD_BITS-1:0]  rd_data_ff;
   logic                  rd_en, wr_en;
   logic [WADDR_W-1:0]    rd_addr, wr_addr;
   logic [WORD_BITS-1:0]  wr_data;

   // Derived values.
   logic [SLOT_W-1:0]     lim;
   logic                  lim_zero;
   logic [SLOT_W-1:0]     nf_start;
   logic [SLOT_W-1:0]     cnt_next;
   logic [SLOT_W-1:0]     cnt_wrap;
   logic [ID_W-1:0]       cnt_issued;
   logic [ID_W:0]         free_diff;
   logic                  free_in_range;
   logic [SLOT_W-1:0]     free_slot;
   logic [WORD_BITS-1:0]  chk_word;
   logic [WORD_BITS-1:0]  range_mask;
   logic [WORD_BITS-1:0]  free_vec;
   logic                  found;
   logic [BIT_W-1:0]      found_bit;
   logic [SLOT_W-1:0]     found_slot;
   logic                  last_word;
   logic [WORD_BITS-1:0]  free_word_data;

   assign lim      = (last_slot_ff > SLOT_MAX) ? SLOT_MAX : last_slot_ff;
   assign lim_zero = (lim == '0);
   assign nf_start = (cursor_ff > lim) ? SLOT_ONE : cursor_ff;
   assign cnt_next = cursor_ff + SLOT_ONE;
   assign cnt_wrap = (cnt_next > lim) ? SLOT_ONE : cnt_next;
   assign cnt_issued = ID_W'(cursor_ff) + ID_W'(id_offset_ff);

   // A borrow out of the subtraction means the ID lies below the offset.
   assign free_diff     = {1'b0, req_data.free_id} - (ID_W + 1)'(id_offset_ff);
   assign free_in_range = !free_diff[ID_W] && (free_diff[ID_W-1:0] != '0) &&
                          (free_diff[ID_W-1:0] <= ID_W'(lim));
   assign free_slot     = free_diff[SLOT_W-1:0];

   // Word under test: words never written since the last clear read as empty.
   always_comb begin
      chk_word   = word_vld_ff[chk_idx_ff] ? rd_data_ff : '0;
      range_mask = '1;
      if (chk_idx_ff == w_lo_ff) begin
         range_mask = range_mask & ({WORD_BITS{1'b1}} << slot_bit(lo_ff));
      end
      if (chk_idx_ff == w_hi_ff) begin
         range_mask = range_mask &
                      ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - slot_bit(hi_ff)));
      end
      free_vec = ~chk_word & range_mask;
   end

   // Lowest free bit of the word.
   always_comb begin
      found     = |free_vec;
      found_bit = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            found_bit = BIT_W'(i);
         end
      end
   end

   assign found_slot = SLOT_W'({chk_idx_ff, found_bit}) + SLOT_ONE;
   assign last_word  = (chk_idx_ff == w_hi_ff);
   assign free_word_data = (word_vld_ff[free_word_ff] ? rd_data_ff : '0) &
                           ~(WORD_BITS'(1) << free_bit_ff);

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      last_slot_in = last_slot_ff;
      id_offset_in = id_offset_ff;
      cursor_in    = cursor_ff;
      word_vld_in  = word_vld_ff;
      rsp_valid_in = 1'b0;
      chk_vld_in   = 1'b0;
      rd_more_in   = rd_more_ff;
      rsp_data_in  = rsp_data_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      w_lo_in      = w_lo_ff;
      w_hi_in      = w_hi_ff;
      rd_ptr_in    = rd_ptr_ff;
      chk_idx_in   = chk_idx_ff;
      pass_b_in    = pass_b_ff;
      next_fit_in  = next_fit_ff;
      nf_start_in  = nf_start_ff;
      free_word_in = free_word_ff;
      free_bit_in  = free_bit_ff;
      rd_en        = 1'b0;
      rd_addr      = rd_ptr_ff;
      wr_en        = 1'b0;
      wr_addr      = chk_idx_ff;
      wr_data      = chk_word | (WORD_BITS'(1) << found_bit);

      if (csr_valid) begin
         unique case (csr_index)
            CSR_ALLOC_MODE: mode_in      = csr_wdata[MODE_W-1:0];
            CSR_LAST_SLOT:  last_slot_in = csr_wdata[SLOT_W-1:0];
            CSR_ID_OFFSET:  id_offset_in = csr_wdata[OFFS_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_data_in.issued_id = '0;
               unique case (req_data.op)
                  OP_ALLOC: begin
                     if (mode_ff == MODE_COUNTER) begin
                        rsp_data_in.issued_id = cnt_issued;
                        cursor_in    = cnt_wrap;
                        rsp_valid_in = 1'b1;
                     end else if (lim_zero) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        next_fit_in = (mode_ff == MODE_NEXT_FIT);
                        lo_in       = (mode_ff == MODE_NEXT_FIT) ? nf_start : SLOT_ONE;
                        hi_in       = lim;
                        nf_start_in = nf_start;
                        pass_b_in   = (mode_ff == MODE_NEXT_FIT) && (nf_start != SLOT_ONE);
                        w_lo_in     = slot_word(lo_in);
                        w_hi_in     = slot_word(lim);
                        rd_ptr_in   = w_lo_in;
                        rd_more_in  = 1'b1;
                        state_in    = ST_SCAN;
                     end
                  end
                  OP_FREE: begin
                     if ((mode_ff != MODE_COUNTER) && free_in_range) begin
                        free_word_in = slot_word(free_slot);
                        free_bit_in  = slot_bit(free_slot);
                        state_in     = ST_FREE_RD;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     word_vld_in  = '0;
                     cursor_in    = SLOT_ONE;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // Reads stream one word a cycle; each word is checked in the cycle after its read.
            if (rd_more_ff) begin
               rd_en      = 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = rd_ptr_ff;
               rd_ptr_in  = rd_ptr_ff + 1'b1;
               rd_more_in = (rd_ptr_ff != w_hi_ff);
            end
            if (chk_vld_ff) begin
               if (found) begin
                  wr_en                 = 1'b1;
                  word_vld_in[chk_idx_ff] = 1'b1;
                  rsp_data_in.issued_id = ID_W'(found_slot) + ID_W'(id_offset_ff);
                  if (next_fit_ff) begin
                     cursor_in = found_slot + SLOT_ONE;
                  end
                  chk_vld_in   = 1'b0;
                  rd_more_in   = 1'b0;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else if (last_word) begin
                  if (pass_b_ff) begin
                     // Wrap around and scan the slots below the start point.
                     lo_in      = SLOT_ONE;
                     hi_in      = nf_start_ff - SLOT_ONE;
                     w_lo_in    = '0;
                     w_hi_in    = slot_word(nf_start_ff - SLOT_ONE);
                     rd_ptr_in  = '0;
                     rd_more_in = 1'b1;
                     pass_b_in  = 1'b0;
                  end else begin
                     rsp_data_in.issued_id = '0;
                     if (next_fit_ff) begin
                        cursor_in = (nf_start_ff == SLOT_ONE) ? (lim + SLOT_ONE)
                                                              : nf_start_ff;
                     end
                     rd_more_in   = 1'b0;
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
            end
         end

         ST_FREE_RD: begin
            rd_en    = 1'b1;
            rd_addr  = free_word_ff;
            state_in = ST_FREE_WR;
         end

         ST_FREE_WR: begin
            wr_en                     = 1'b1;
            wr_addr                   = free_word_ff;
            wr_data                   = free_word_data;
            word_vld_in[free_word_ff] = 1'b1;
            rsp_valid_in              = 1'b1;
            state_in                  = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_data_in.cursor = cursor_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_FIRST_FIT;
         last_slot_ff <= SLOT_ONE;
         id_offset_ff <= '0;
         cursor_ff    <= SLOT_ONE;
         word_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         chk_vld_ff   <= 1'b0;
         rd_more_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         last_slot_ff <= last_slot_in;
         id_offset_ff <= id_offset_in;
         cursor_ff    <= cursor_in;
         word_vld_ff  <= word_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_vld_ff   <= chk_vld_in;
         rd_more_ff   <= rd_more_in;
      end
      rsp_data_ff  <= rsp_data_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      w_lo_ff      <= w_lo_in;
      w_hi_ff      <= w_hi_in;
      rd_ptr_ff    <= rd_ptr_in;
      chk_idx_ff   <= chk_idx_in;
      pass_b_ff    <= pass_b_in;
      next_fit_ff  <= next_fit_in;
      nf_start_ff  <= nf_start_in;
      free_word_ff <= free_word_in;
      free_bit_ff  <= free_bit_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bitmap_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= bitmap_ff[rd_addr];
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   `ASSERT_IMPL(a_rsp_when_idle, rsp_valid, !busy, "result word while still busy")
   `ASSERT_NEXT(a_accept_progress, start && !busy, busy || rsp_valid, "accepted word dropped")
   `ASSERT_ALWAYS(a_cursor_range, (cursor_ff != '0) && (cursor_ff <= SLOT_MAX + SLOT_ONE), "cursor out of range")
   `ASSERT_IMPL(a_check_in_scan, chk_vld_ff, state_ff == ST_SCAN, "word check outside a search")

endmodule

// File: tb/unique_id_bitmap_allocator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_id_bitmap_allocator_core_tb
// Drives allocate, free, clear and no-op words into the ID allocator under
// every allocation mode and a range of pool sizes and offsets. A behavioral
// copy of the bitmap and search cursor predicts each response that a scripted
// row does not give. The monitor compares every response strobe against the oldest expectation.
// ----------------------------------------------------------------------------
module unique_id_bitmap_allocator_core_tb;
   import uida_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int ITEM_GOAL = 900;

   typedef struct {
      bit                    is_reg;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] reg_val;
      req_type               word;
      bit                    typed;
      rsp_type               want;
   } script_row_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow of the configuration registers and of the allocator state.
   logic [MODE_W-1:0] cfg_mode;
   logic [SLOT_W-1:0] cfg_last;
   logic [OFFS_W-1:0] cfg_offset;
   bit [SLOTS:0]      slot_used;
   int                hunt_pos;

   rsp_type        pending_ids[$];
   script_row_type script_q[$];
   int             live_slots[$];
   int             idle_pct;
   int             words_sent;
   int             fault_count = 0;
   rsp_type        head;

   unique_id_bitmap_allocator_core uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   initial begin
      #10ms;
      $display("unique_id_bitmap_allocator_core: mismatch");
      $finish;
   end

   // Applies one word to the shadow state and returns the response it earns.
   function automatic rsp_type predict_alloc(input req_type w);
      int      lim, slot, i, fid, base, issued;
      rsp_type res;
      lim    = (cfg_last > SLOTS) ? SLOTS : int'(cfg_last);
      base   = int'(cfg_offset);
      slot   = 0;
      issued = 0;
      case (w.op)
         OP_ALLOC: begin
            if (cfg_mode == MODE_COUNTER) begin
               slot = hunt_pos;
               hunt_pos++;
               if (hunt_pos > lim) hunt_pos = 1;
            end else if (cfg_mode == MODE_NEXT_FIT) begin
               // The cursor wraps before each probe, so a stale cursor restarts at 1.
               for (i = 0; i < lim && slot == 0; i++) begin
                  if (hunt_pos > lim) hunt_pos = 1;
                  if (!slot_used[hunt_pos]) begin
                     slot = hunt_pos;
                     slot_used[hunt_pos] = 1'b1;
                  end
                  hunt_pos++;
               end
            end else begin
               for (i = 1; i <= lim && slot == 0; i++) begin
                  if (!slot_used[i]) slot = i;
               end
               if (slot != 0) slot_used[slot] = 1'b1;
            end
            if (slot != 0) issued = slot + base;
         end
         OP_FREE: begin
            fid = int'(w.free_id);
            if (cfg_mode != MODE_COUNTER && fid >= base && fid < base + lim + 1) begin
               if (fid - base >= 1) slot_used[fid - base] = 1'b0;
            end
         end
         OP_CLEAR: begin
            slot_used = '0;
            hunt_pos  = 1;
         end
         default: ;
      endcase
      res.issued_id = issued[ID_W-1:0];
      res.cursor    = hunt_pos[SLOT_W-1:0];
      return res;
   endfunction

   function automatic void plan_reg(input logic [CSR_IDX_W-1:0] idx,
                                    input logic [CSR_DATA_W-1:0] val);
      script_row_type row;
      row.is_reg  = 1'b1;
      row.reg_idx = idx;
      row.reg_val = val;
      row.word    = '0;
      row.typed   = 1'b0;
      row.want    = '0;
      script_q.push_back(row);
   endfunction

   function automatic void plan_word(input logic [OP_W-1:0] op, input logic [ID_W-1:0] fid,
                                     input bit typed, input logic [ID_W-1:0] iss,
                                     input logic [SLOT_W-1:0] cur);
      script_row_type row;
      row.is_reg         = 1'b0;
      row.reg_idx        = '0;
      row.reg_val        = '0;
      row.word.op        = op;
      row.word.free_id   = fid;
      row.typed          = typed;
      row.want.issued_id = iss;
      row.want.cursor    = cur;
      script_q.push_back(row);
   endfunction

   // Holds the request side quiet until every outstanding response is back.
   task automatic settle_pool();
      start <= 1'b0;
      do @(posedge clock); while (pending_ids.size() != 0);
   endtask

   // Leaves csr_valid high; the caller lowers it after the last write of a batch.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ALLOC_MODE: cfg_mode   = val[MODE_W-1:0];
         CSR_LAST_SLOT:  cfg_last   = val[SLOT_W-1:0];
         CSR_ID_OFFSET:  cfg_offset = val[OFFS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_word(input req_type w, input bit typed, input rsp_type want,
                            output rsp_type guess);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      guess = predict_alloc(w);
      pending_ids.push_back(typed ? want : guess);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_ids.size() == 0) begin
            $error("response with nothing outstanding: issued_id %0d cursor %0d",
                   rsp_data.issued_id, rsp_data.cursor);
            fault_count++;
         end else begin
            head = pending_ids.pop_front();
            if (rsp_data.issued_id !== head.issued_id) begin
               $error("issued_id: expected %0d, got %0d", head.issued_id, rsp_data.issued_id);
               fault_count++;
            end
            if (rsp_data.cursor !== head.cursor) begin
               $error("cursor: expected %0d, got %0d", head.cursor, rsp_data.cursor);
               fault_count++;
            end
         end
      end
   end

   initial begin
      script_row_type  row;
      rsp_type         guess;
      rsp_type         none;
      req_type         w;
      int              k, span, phase, pick, lim, pos, guard;

      cfg_mode   = MODE_FIRST_FIT;
      cfg_last   = 1;
      cfg_offset = 0;
      slot_used  = '0;
      hunt_pos   = 1;
      idle_pct   = 0;
      words_sent = 0;
      none       = '0;

      // Out of reset: one slot, first-fit, no offset.
      plan_word(OP_ALLOC, 0, 1, 1, 1);
      plan_word(OP_ALLOC, 0, 1, 0, 1);
      plan_word(OP_FREE, 1, 1, 0, 1);
      plan_word(OP_NOP, 17'h1FFFF, 1, 0, 1);
      plan_reg(CSR_SPARE, 16'hFFFF);
      plan_reg(CSR_ALLOC_MODE, CSR_DATA_W'(MODE_NEXT_FIT));
      plan_reg(CSR_LAST_SLOT, 4);
      plan_reg(CSR_ID_OFFSET, 16'hFFFF);
      plan_word(OP_ALLOC, 0, 1, 65536, 2);
      plan_word(OP_ALLOC, 0, 0, 0, 0);
      plan_word(OP_ALLOC, 0, 0, 0, 0);
      plan_word(OP_ALLOC, 0, 0, 0, 0);
      // Pool is full here, so next-fit runs a whole circle and fails.
      plan_word(OP_ALLOC, 0, 0, 0, 0);
      plan_word(OP_FREE, 65535, 0, 0, 0);
      plan_word(OP_FREE, 17'h1FFFF, 0, 0, 0);
      plan_word(OP_FREE, 65534, 0, 0, 0);
      plan_word(OP_FREE, 65538, 0, 0, 0);
      plan_word(OP_FREE, 65540, 0, 0, 0);
      plan_word(OP_ALLOC, 0, 0, 0, 0);
      // Shrink the pool below the cursor, then let the counter issue the stale cursor.
      plan_reg(CSR_LAST_SLOT, 2);
      plan_reg(CSR_ALLOC_MODE, CSR_DATA_W'(MODE_COUNTER));
      plan_word(OP_ALLOC, 0, 0, 0, 0);
      plan_word(OP_ALLOC, 0, 0, 0, 0);
      plan_word(OP_FREE, 65536, 0, 0, 0);
      plan_word(OP_CLEAR, 0, 1, 0, 1);
      // Empty pool: the searches fail and the counter keeps issuing slot 1.
      plan_reg(CSR_LAST_SLOT, 0);
      plan_reg(CSR_ALLOC_MODE, 16'hFFFF);
      plan_reg(CSR_ID_OFFSET, 0);
      plan_word(OP_ALLOC, 0, 1, 0, 1);
      plan_word(OP_ALLOC, 0, 0, 0, 0);
      plan_reg(CSR_ALLOC_MODE, CSR_DATA_W'(MODE_COUNTER));
      plan_word(OP_ALLOC, 0, 1, 1, 1);
      plan_reg(CSR_ALLOC_MODE, CSR_DATA_W'(MODE_NEXT_FIT));
      plan_word(OP_ALLOC, 0, 0, 0, 0);
      plan_reg(CSR_LAST_SLOT, 16'hFFFF);
      plan_reg(CSR_ALLOC_MODE, CSR_DATA_W'(MODE_FIRST_FIT));
      plan_word(OP_ALLOC, 0, 1, 1, 1);
      plan_word(OP_FREE, ID_W'(SLOTS), 0, 0, 0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < script_q.size(); k++) begin
         row = script_q[k];
         if (row.is_reg) begin
            settle_pool();
            write_reg(row.reg_idx, row.reg_val);
            csr_valid <= 1'b0;
         end else begin
            send_word(row.word, row.typed, row.want, guess);
         end
      end

      phase = 0;
      while (words_sent < ITEM_GOAL) begin
         case (phase % 4)
            1: idle_pct = 51;
            3: idle_pct = 9;
            default: idle_pct = 0;
         endcase
         settle_pool();
         write_reg(CSR_ALLOC_MODE, CSR_DATA_W'($urandom_range(3)));
         pick = $urandom_range(99);
         // Mostly small pools; full size, oversize and empty pools now and then.
         if (pick < 8) write_reg(CSR_LAST_SLOT, 0);
         else if (pick < 16) write_reg(CSR_LAST_SLOT, CSR_DATA_W'(SLOTS));
         else if (pick < 22)
            write_reg(CSR_LAST_SLOT, CSR_DATA_W'($urandom_range(2047, SLOTS + 1)));
         else if (pick < 26) write_reg(CSR_LAST_SLOT, CSR_DATA_W'($urandom_range(65535)));
         else write_reg(CSR_LAST_SLOT, CSR_DATA_W'($urandom_range(40, 1)));
         pick = $urandom_range(99);
         if (pick < 10) write_reg(CSR_ID_OFFSET, 0);
         else if (pick < 20) write_reg(CSR_ID_OFFSET, 16'hFFFF);
         else write_reg(CSR_ID_OFFSET, CSR_DATA_W'($urandom_range(65535)));
         csr_valid <= 1'b0;

         lim  = (cfg_last > SLOTS) ? SLOTS : int'(cfg_last);
         span = $urandom_range(60, 20);
         for (k = 0; k < span; k++) begin
            if ((phase == 1 && k == span / 2) || $urandom_range(99) < 2) settle_pool();
            pick      = $urandom_range(99);
            w.free_id = ID_W'($urandom_range(131071));
            if (pick < 55) begin
               w.op = OP_ALLOC;
            end else if (pick < 80 && live_slots.size() != 0) begin
               w.op      = OP_FREE;
               pos       = $urandom_range(live_slots.size() - 1);
               w.free_id = ID_W'(live_slots[pos] + int'(cfg_offset));
               live_slots.delete(pos);
            end else if (pick < 90) begin
               w.op = OP_FREE;
            end else if (pick < 94) begin
               // IDs right at the edges of the valid range.
               w.op = OP_FREE;
               case ($urandom_range(3))
                  0: w.free_id = ID_W'(int'(cfg_offset) - 1);
                  1: w.free_id = ID_W'(cfg_offset);
                  2: w.free_id = ID_W'(int'(cfg_offset) + lim);
                  default: w.free_id = ID_W'(int'(cfg_offset) + lim + 1);
               endcase
            end else if (pick < 97) begin
               w.op = OP_CLEAR;
            end else begin
               w.op = OP_NOP;
            end
            send_word(w, 1'b0, none, guess);
            if (w.op == OP_ALLOC && guess.issued_id != 0 && cfg_mode != MODE_COUNTER)
               live_slots.push_back(int'(guess.issued_id) - int'(cfg_offset));
            if (w.op == OP_CLEAR) live_slots.delete();
            words_sent++;
         end
         phase++;
      end

      start <= 1'b0;
      guard = 0;
      while (pending_ids.size() != 0 && guard < 400) begin
         @(posedge clock);
         guard++;
      end
      if (pending_ids.size() != 0) begin
         $error("%0d expected responses never arrived", pending_ids.size());
         fault_count++;
      end
      repeat (40) @(posedge clock);
      if (fault_count == 0) begin
         $display("unique_id_bitmap_allocator_core: match");
      end else begin
         $display("unique_id_bitmap_allocator_core: mismatch");
      end
      $finish;
   end

endmodule
